@@ hdl/lesf_pkg.sv @@
// Shared constants and codes for the largest empty square finder.
package lesf_pkg;

    localparam int CELL_W     = 8;
    localparam int POS_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [CELL_W-1:0] OBSTACLE_CHAR = 8'h6F;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

endpackage

@@ hdl/lesf_cell_if.sv @@
// Cell request channel carrying one map character.
interface lesf_cell_if
    import lesf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_char;

    modport source (output valid, output cell_char, input ready);
    modport sink (input valid, input cell_char, output ready);
endinterface

@@ hdl/lesf_result_if.sv @@
// Result request channel carrying the best square of one grid.
interface lesf_result_if
    import lesf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  square_top;
    logic [POS_W-1:0]  square_left;
    logic [SIZE_W-1:0] square_size;

    modport source (output valid, output square_top, output square_left,
                    output square_size, input ready);
    modport sink (input valid, input square_top, input square_left,
                  input square_size, output ready);
endinterface

@@ hdl/lesf_cfg_if.sv @@
// Configuration write channel carrying a register index and write data.
interface lesf_cfg_if
    import lesf_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/lesf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lesf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/largest_empty_square_finder_core.sv @@
// Top level of the largest empty square finder.
//
// Map cells enter on the cell channel, one request per cell, in row-major
// order. A cell holding 'o' is an obstacle and every other cell is free.
// The grid size comes from the grid_width and grid_height registers, which
// the user writes on the configuration channel only while no grid is in
// progress; the block itself does not enforce this. After the last cell of
// a grid, one request on the result channel gives the top-left corner and
// side of the largest obstacle-free square; ties go to the square whose
// corner comes first in row-major order. One cell is accepted every cycle,
// except in the stall described below. A cell passes through one stage that
// waits for the previous-row line store, whose read is registered; from that
// stage the result goes to the output register and the result channel.
// The result waits in an output register; while it is not taken the block
// still accepts cells, and it stalls only when the last cell of the next grid
// finds that register still full.
// Reset clears the scan state and sets both registers to 1. The line store
// needs no clearing, since each row is written before the next one reads it.
module largest_empty_square_finder_core
    import lesf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lesf_cell_if.sink            map_cell,
    lesf_result_if.source        result,
    lesf_cfg_if.sink             cfg
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [CFG_DATA_W-1:0] grid_width_reg;
    logic [CFG_DATA_W-1:0] grid_height_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;

    logic              p_valid_reg, p_valid_next;
    logic              p_obst_reg;
    logic [COL_W-1:0]  p_col_reg;
    logic [POS_W-1:0]  p_row_reg;
    logic              p_last_col_reg;
    logic              p_last_row_reg;
    logic              p_fwd_reg;
    logic [SIZE_W-1:0] p_fwd_data_reg;

    logic [SIZE_W-1:0] left_reg, left_next;
    logic [SIZE_W-1:0] diag_reg, diag_next;
    logic [SIZE_W-1:0] best_size_reg, best_size_next;
    logic [POS_W-1:0]  best_top_reg, best_top_next;
    logic [POS_W-1:0]  best_left_reg, best_left_next;

    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_top_reg;
    logic [POS_W-1:0]  out_left_reg;
    logic [SIZE_W-1:0] out_size_reg;

    logic              cell_accept;
    logic              p_end;
    logic              p_advance;
    logic              last_col;
    logic              last_row;
    logic [COL_W:0]    col_plus;
    logic [POS_W:0]    row_plus;
    logic [SIZE_W-1:0] rd_data;
    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] left;
    logic [SIZE_W-1:0] diag;
    logic [SIZE_W-1:0] min_ul;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] size;
    logic              better;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_DATA_W'(1);
            grid_height_reg <= CFG_DATA_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg.data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg.data;
            endcase
        end
    end

    assign p_end          = p_last_col_reg && p_last_row_reg;
    assign p_advance      = p_valid_reg && (!p_end || !out_valid_reg || result.ready);
    assign map_cell.ready = !p_valid_reg || p_advance;
    assign cell_accept    = map_cell.valid && map_cell.ready;

    assign col_plus = {1'b0, col_reg} + (COL_W+1)'(1);
    assign row_plus = {1'b0, row_reg} + (POS_W+1)'(1);
    assign last_col = (32'(col_plus) >= 32'(grid_width_reg)) ||
                      (32'(col_plus) >= MAX_WIDTH);
    assign last_row = (32'(row_plus) >= 32'(grid_height_reg)) ||
                      (32'(row_plus) >= MAX_HEIGHT);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cell_accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_plus[POS_W-1:0];
            end
            else
            begin
                col_next = col_plus[COL_W-1:0];
            end
        end
    end

    assign p_valid_next = cell_accept || (p_valid_reg && !p_advance);

    lesf_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (p_advance),
        .wr_addr (p_col_reg),
        .wr_data (size),
        .rd_en   (cell_accept),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        up     = '0;
        left   = '0;
        diag   = '0;
        if (p_row_reg != '0)
        begin
            up = p_fwd_reg ? p_fwd_data_reg : rd_data;
        end
        if (p_col_reg != '0)
        begin
            left = left_reg;
            if (p_row_reg != '0)
            begin
                diag = diag_reg;
            end
        end
        min_ul  = (up < left) ? up : left;
        min_all = (min_ul < diag) ? min_ul : diag;
        size    = p_obst_reg ? '0 : min_all + SIZE_W'(1);
        better  = size > best_size_reg;
    end

    always_comb
    begin
        left_next      = left_reg;
        diag_next      = diag_reg;
        best_size_next = best_size_reg;
        best_top_next  = best_top_reg;
        best_left_next = best_left_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (p_advance)
        begin
            if (better)
            begin
                best_size_next = size;
                best_top_next  = POS_W'(32'(p_row_reg) + 1 - 32'(size));
                best_left_next = POS_W'(32'(p_col_reg) + 1 - 32'(size));
            end
            left_next = size;
            diag_next = up;
            if (p_last_col_reg)
            begin
                left_next = '0;
                diag_next = '0;
                if (p_last_row_reg)
                begin
                    out_valid_next = 1'b1;
                    best_size_next = '0;
                    best_top_next  = '0;
                    best_left_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            p_valid_reg   <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_top_reg  <= '0;
            best_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            p_valid_reg   <= p_valid_next;
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            best_size_reg <= best_size_next;
            best_top_reg  <= best_top_next;
            best_left_reg <= best_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_accept)
        begin
            p_obst_reg     <= (map_cell.cell_char == OBSTACLE_CHAR);
            p_col_reg      <= col_reg;
            p_row_reg      <= row_reg;
            p_last_col_reg <= last_col;
            p_last_row_reg <= last_row;
            p_fwd_reg      <= p_advance && (p_col_reg == col_reg);
            p_fwd_data_reg <= size;
        end
        if (p_advance && p_end)
        begin
            out_top_reg  <= better ? POS_W'(32'(p_row_reg) + 1 - 32'(size))
                                   : best_top_reg;
            out_left_reg <= better ? POS_W'(32'(p_col_reg) + 1 - 32'(size))
                                   : best_left_reg;
            out_size_reg <= better ? size : best_size_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.square_top  = out_top_reg;
    assign result.square_left = out_left_reg;
    assign result.square_size = out_size_reg;

endmodule
